>>> design/s7sb_pkg.sv
// ----------------------------------------------------------------------------
// s7sb_pkg
// Shared constants and the digit-to-segment lookup for the score display
// byte stream.
// ----------------------------------------------------------------------------
package s7sb_pkg;

    localparam int SCORE_W   = 32;
    localparam int MAX_W     = 20;
    localparam int DIGIT_W   = 4;
    localparam int BYTE_W    = 8;
    localparam int PATTERN_W = 16;
    localparam int DIGIT_SLOTS = 8;

    localparam logic [MAX_W-1:0]  MAX_SCORE_RESET = 20'd999999;
    localparam logic [BYTE_W-1:0] ADDR_BYTE       = 8'h00;

    // ceil(2^35 / 10): (v * RECIP_10) >> 35 is v / 10 for any 32-bit v
    localparam logic [31:0] RECIP_10       = 32'hCCCC_CCCD;
    localparam int          RECIP_10_SHIFT = 35;

    // segment wiring: bit 8 = A, 7..2 = B..G, 1..0 = decimal points
    localparam logic [PATTERN_W-1:0] SEG_0 = 16'h01F8;
    localparam logic [PATTERN_W-1:0] SEG_1 = 16'h00C0;
    localparam logic [PATTERN_W-1:0] SEG_2 = 16'h01B4;
    localparam logic [PATTERN_W-1:0] SEG_3 = 16'h01E4;
    localparam logic [PATTERN_W-1:0] SEG_4 = 16'h00CC;
    localparam logic [PATTERN_W-1:0] SEG_5 = 16'h016C;
    localparam logic [PATTERN_W-1:0] SEG_6 = 16'h017C;
    localparam logic [PATTERN_W-1:0] SEG_7 = 16'h01C0;
    localparam logic [PATTERN_W-1:0] SEG_8 = 16'h01FC;
    localparam logic [PATTERN_W-1:0] SEG_9 = 16'h01EC;

    function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [PATTERN_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = SEG_0;
            4'd1:    pat = SEG_1;
            4'd2:    pat = SEG_2;
            4'd3:    pat = SEG_3;
            4'd4:    pat = SEG_4;
            4'd5:    pat = SEG_5;
            4'd6:    pat = SEG_6;
            4'd7:    pat = SEG_7;
            4'd8:    pat = SEG_8;
            4'd9:    pat = SEG_9;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

>>> design/s7sb_front.sv
// ----------------------------------------------------------------------------
// s7sb_front
// Accepts scores, clamps them to the limit register and splits the clamped
// value into decimal digits, one digit per cycle, then pushes the digit set.
// ----------------------------------------------------------------------------
module s7sb_front #(
    parameter int NUM_DIGITS = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [s7sb_pkg::MAX_W-1:0]       score_cap,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [s7sb_pkg::SCORE_W-1:0]     s_tdata,
    output logic                             push_valid,
    input  logic                             push_full,
    output logic [NUM_DIGITS*4-1:0]          push_data
);
    import s7sb_pkg::*;

    localparam int DIGS_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W  = $clog2(NUM_DIGITS + 1);
    localparam int PROD_W = MAX_W + 32;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAX_W-1:0]  val_reg, val_next;
    logic [DIGS_W-1:0] dig_reg, dig_next;

    logic                      done;
    logic                      push;
    logic                      accept;
    logic [PROD_W-1:0]         prod;
    logic [MAX_W-1:0]          quot;
    logic [MAX_W+3:0]          quot_x10;
    logic [MAX_W-1:0]          diff;
    logic [DIGS_W+DIGIT_W-1:0] dig_shift;
    logic [MAX_W-1:0]          clamped;

    assign done     = busy_reg && (cnt_reg == CNT_W'(NUM_DIGITS));
    assign push     = done && !push_full;
    assign s_tready = !busy_reg || push;
    assign accept   = s_tvalid && s_tready;

    assign push_valid = done;
    assign push_data  = dig_reg;

    // divide by ten through the reciprocal, remainder from q*8 + q*2
    assign prod      = PROD_W'(val_reg) * PROD_W'(RECIP_10);
    assign quot      = MAX_W'(prod[PROD_W-1:RECIP_10_SHIFT]);
    assign quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign diff      = val_reg - quot_x10[MAX_W-1:0];
    // new digit enters at the top, so the least significant one ends in slot 0
    assign dig_shift = {diff[DIGIT_W-1:0], dig_reg};

    assign clamped = (s_tdata > {{(SCORE_W-MAX_W){1'b0}}, score_cap}) ?
                     score_cap : s_tdata[MAX_W-1:0];

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        dig_next  = dig_reg;
        if (busy_reg && !done) begin
            val_next = quot;
            dig_next = dig_shift[DIGS_W+DIGIT_W-1:DIGIT_W];
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (push) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        dig_reg <= dig_next;
    end

endmodule

>>> design/s7sb_fifo.sv
// ----------------------------------------------------------------------------
// s7sb_fifo
// Small register queue of digit sets between the converter and the
// byte serializer.
// ----------------------------------------------------------------------------
module s7sb_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/s7sb_back.sv
// ----------------------------------------------------------------------------
// s7sb_back
// Serializes one digit set into the display write: address byte, then the
// low and high segment byte of each digit, most significant digit first.
// ----------------------------------------------------------------------------
module s7sb_back #(
    parameter int NUM_DIGITS = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  logic [NUM_DIGITS*4-1:0]       q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [s7sb_pkg::BYTE_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import s7sb_pkg::*;

    localparam int DIGS_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W  = $clog2(NUM_DIGITS + 1);

    logic              active_reg, active_next;
    logic              hi_reg, hi_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIGS_W-1:0] dig_reg, dig_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;

    logic                 advance;
    logic [PATTERN_W-1:0] pattern;

    assign advance  = !valid_reg || m_tready;
    assign pattern  = seg_pattern(dig_reg[DIGS_W-1 -: DIGIT_W]);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        active_next = active_reg;
        hi_next     = hi_reg;
        cnt_next    = cnt_reg;
        dig_next    = dig_reg;
        valid_next  = valid_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        if (advance) begin
            if (active_reg) begin
                valid_next = 1'b1;
                if (!hi_reg) begin
                    data_next = pattern[BYTE_W-1:0];
                    last_next = 1'b0;
                    hi_next   = 1'b1;
                end else begin
                    data_next = pattern[PATTERN_W-1:BYTE_W];
                    last_next = (cnt_reg == CNT_W'(1));
                    hi_next   = 1'b0;
                    dig_next  = dig_reg << DIGIT_W;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        active_next = 1'b0;
                    end
                end
            end else if (q_not_empty) begin
                // address byte goes out while the digit set is loaded
                q_pop       = 1'b1;
                valid_next  = 1'b1;
                data_next   = ADDR_BYTE;
                last_next   = 1'b0;
                dig_next    = q_data;
                cnt_next    = CNT_W'(NUM_DIGITS);
                hi_next     = 1'b0;
                active_next = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            hi_reg     <= 1'b0;
            cnt_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            hi_reg     <= hi_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg  <= dig_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

>>> design/score_to_seven_segment_bytes_unit.sv
// ----------------------------------------------------------------------------
// score_to_seven_segment_bytes_unit
// Turns a binary score into the byte stream of one display-RAM write.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one 32-bit score per word. The score is clamped to
//   the score cap (written through cfg_wr_en / cfg_wr_data, 999999 after
//   reset) and split into NUM_DIGITS decimal digits.
//   m_ channel carries 1 + 2*NUM_DIGITS bytes per score: address 0x00, then
//   low and high segment byte per digit, most significant digit first;
//   m_tlast marks the final high byte.
// Timing:
//   the converter takes one divide-by-ten step per cycle, then hands the
//   digit set to the queue; the byte serializer sends one byte per cycle
//   while m_tready is high and a digit set is queued.
//   A two-deep queue of digit sets lets the converter keep taking scores
//   while the serializer is busy or stalled.
// Reset and stall:
//   reset empties the queue, drops any pending byte and restores the cap.
//   When m_tready is low the output byte holds; s_tready stays low while the
//   converter splits a score and while its digit set waits on a full queue.
// ----------------------------------------------------------------------------
module score_to_seven_segment_bytes_unit #(
    parameter int NUM_DIGITS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [s7sb_pkg::MAX_W-1:0]         cfg_wr_data,  // score cap
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [s7sb_pkg::SCORE_W-1:0]       s_tdata,      // score
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [s7sb_pkg::BYTE_W-1:0]        m_tdata,      // data_byte
    output logic                               m_tlast       // last_byte
);
    import s7sb_pkg::*;

    localparam int DIGS_W = NUM_DIGITS * DIGIT_W;

    logic [MAX_W-1:0]  score_cap_reg;
    logic              push_valid;
    logic              push_full;
    logic [DIGS_W-1:0] push_data;
    logic              q_pop;
    logic              q_not_empty;
    logic [DIGS_W-1:0] q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_cap_reg <= MAX_SCORE_RESET;
        end else if (cfg_wr_en) begin
            score_cap_reg <= cfg_wr_data;
        end
    end

    s7sb_front #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .score_cap (score_cap_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push_valid(push_valid),
        .push_full (push_full),
        .push_data (push_data)
    );

    s7sb_fifo #(
        .WIDTH(DIGS_W),
        .DEPTH(2)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid && !push_full),
        .push_data(push_data),
        .full     (push_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_data)
    );

    s7sb_back #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(q_not_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // the closing byte of a write holds no segment other than A
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[BYTE_W-1:1] == '0)
        else $error("last byte carries more than segment A");

    // a valid byte right after an accepted closing byte is the address byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_tvalid && m_tready && m_tlast) && m_tvalid |-> m_tdata == ADDR_BYTE)
        else $error("write did not start with the address byte");

    // the serializer only pops a queue that holds a digit set
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("pop from empty digit queue");

    // converter never takes a score while its finished digits cannot leave
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && push_full |-> !s_tready)
        else $error("score taken while converter output is blocked");

endmodule

>>> tb/score_to_seven_segment_bytes_unit_tb.sv
// ----------------------------------------------------------------------------
// score_to_seven_segment_bytes_unit_tb
// Drives binary scores into the display byte-stream unit and checks every
// byte against a local predictor: clamp to the score cap, split into decimal
// digits, map through the segment table, and emit address plus low/high
// pattern bytes. Runs several cap settings and idle patterns on both
// channels, including a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module score_to_seven_segment_bytes_unit_tb;
    import s7sb_pkg::*;

    localparam int DIGITS           = 6;
    localparam int SETTLE_CYCLES    = DIGITS + 6;
    localparam int QUIET_LIMIT      = 5000;
    localparam int HOLD_CYCLES      = 240;
    localparam int RANDOM_PER_PHASE = 48;
    localparam int NUM_SETTINGS     = 6;
    localparam int MAX_REPORTS      = 30;

    localparam logic [BYTE_W-1:0] START_ADDR = 8'h00;

    // segment patterns for digits 0..9, bit 8 = A, bits 7..2 = B..G
    localparam logic [PATTERN_W-1:0] DIGIT_SEGS [10] = '{
        16'h01F8, 16'h00C0, 16'h01B4, 16'h01E4, 16'h00CC,
        16'h016C, 16'h017C, 16'h01C0, 16'h01FC, 16'h01EC
    };

    class segment_byte_board;
        logic [MAX_W-1:0] score_cap;
        logic [BYTE_W:0]  pending_bytes [$];  // {last_byte, data_byte}
        int errors;
        int scores;
        int clamped;
        int bytes_seen;

        function new();
            score_cap  = MAX_SCORE_RESET;
            errors     = 0;
            scores     = 0;
            clamped    = 0;
            bytes_seen = 0;
        endfunction

        function void note_score(logic [SCORE_W-1:0] score);
            logic [SCORE_W-1:0]   v;
            logic [3:0]           digs [DIGITS];
            logic [PATTERN_W-1:0] pat;
            v = score;
            if (score > SCORE_W'(score_cap)) begin
                v = SCORE_W'(score_cap);
                clamped++;
            end
            // least significant digit first; digits above the top one are dropped
            for (int i = 0; i < DIGITS; i++) begin
                digs[i] = 4'(v % 10);
                v = v / 10;
            end
            pending_bytes.push_back({1'b0, START_ADDR});
            for (int i = DIGITS - 1; i >= 0; i--) begin
                pat = DIGIT_SEGS[digs[i]];
                pending_bytes.push_back({1'b0, pat[7:0]});
                pending_bytes.push_back({(i == 0) ? 1'b1 : 1'b0, pat[15:8]});
            end
            scores++;
        endfunction

        function void check_byte(logic [BYTE_W-1:0] data, logic last);
            logic [BYTE_W:0] want;
            bytes_seen++;
            if (pending_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, %s %02h %b",
                             $time, "actual data_byte/last_byte", data, last);
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want[BYTE_W-1:0]) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: data_byte expected %02h actual %02h",
                             $time, want[BYTE_W-1:0], data);
            end
            if (last !== want[BYTE_W]) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: last_byte expected %b actual %b", $time, want[BYTE_W], last);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [MAX_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [SCORE_W-1:0] s_tdata     = '0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [BYTE_W-1:0]  m_tdata;
    logic               m_tlast;

    segment_byte_board board = new();

    int src_idle_pct  = 0;
    int dst_idle_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int settings_used = 0;

    score_to_seven_segment_bytes_unit #(
        .NUM_DIGITS(DIGITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: check accepted bytes, then pick tready for the next edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_byte(m_tdata, m_tlast);
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("score_to_seven_segment_bytes_unit_tb failed");
            $finish;
        end
    end

    // entered at a clock edge; leaves tvalid high after the handshake
    task automatic send_score(input logic [SCORE_W-1:0] score);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= score;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_score(score);
    endtask

    task automatic drain_scores();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_score_cap(input logic [MAX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.score_cap = value;
        settings_used++;
    endtask

    initial begin
        logic [SCORE_W-1:0] directed [];
        logic [SCORE_W-1:0] above_range [];
        logic [MAX_W-1:0]   settings [NUM_SETTINGS];
        logic [SCORE_W-1:0] limit;
        logic [SCORE_W-1:0] score;

        directed = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd123456, 32'd654321,
            32'd789012, 32'd888888, 32'd505050, 32'd999998, 32'd999999, 32'd1000000,
            32'd1048575, 32'd1048576, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
        };
        above_range = '{
            32'd1048575, 32'd1000000, 32'd1048574, 32'hFFFF_FFFF
        };
        settings = '{20'hFFFFF, 20'd0, 20'd999999, 20'd0, 20'd1, 20'd4321};
        settings[3] = MAX_W'($urandom_range(2, 999998));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 17;
        dst_idle_pct = 61;
        foreach (directed[i])
            send_score(directed[i]);
        drain_scores();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            if (p == 2) begin
                src_idle_pct = 61;
                dst_idle_pct = 17;
            end else if (p == 4) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            write_score_cap(settings[p]);
            // register above the six-digit range: top digit falls away
            if (p == 0)
                foreach (above_range[i])
                    send_score(above_range[i]);
            // long output stall while scores keep coming
            if (p == 4)
                hold_request = HOLD_CYCLES;
            limit = SCORE_W'(board.score_cap);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                case ($urandom_range(0, 3))
                    0:       score = $urandom;
                    1:       score = $urandom_range(0, limit);
                    2:       score = limit + $urandom_range(0, 4) - 2;
                    default: score = $urandom >> $urandom_range(0, 31);
                endcase
                send_score(score);
            end
            drain_scores();
        end

        $display("covered %0d scores (%0d clamped), %0d bytes checked", board.scores,
                 board.clamped, board.bytes_seen);
        $display("score cap written %0d times, including 0, 999999 and 1048575", settings_used);
        if (board.errors == 0 && board.pending_bytes.size() == 0) begin
            $display("score_to_seven_segment_bytes_unit_tb passed");
        end else begin
            $display("score_to_seven_segment_bytes_unit_tb failed");
        end
        $finish;
    end

endmodule
